// ===== rtl/swmm_pkg.sv =====
// Shared constants for the sliding-window minimum/maximum block.
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

    // Default number of samples in the window.
    localparam int WINDOW_DEF = 24;

    // Default sample width in bits (two's complement, 1/16 degree units).
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of the reported sample count.
    localparam int HELD_W = 5;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_min_max_core.sv =====
// Sliding-window minimum/maximum over a ring of the most recent samples.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted sample beat is written into a ring of the last WINDOW samples,
// overwriting the oldest once the ring is full. One result beat follows per
// sample. It carries the minimum and maximum of all held samples, the new one
// included, and the number of held samples. That count is reported modulo 32
// when WINDOW exceeds 31. After a sample is accepted, the scan reads the held
// entries one by one and folds them into the running extremes. The done state
// then loads the result into the output register, waiting while a previous
// result there is still stalled, and returns to idle for the next sample.
// The ring has one write port and one registered read port, and the scan reads
// one entry per cycle. The entries are fed through one shared pair of signed
// comparators. A new sample is taken only while the sequencer is idle. A
// finished result waits in the output register, so the next sample may be
// accepted before the result is taken.
module sliding_window_min_max_core
    import swmm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0]      window_min,
    output logic signed [SAMPLE_BITS-1:0]      window_max,
    output logic        [HELD_W-1:0]           samples_held
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  write_slot_reg, write_slot_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;

    // Read issue side of the scan.
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              issuing_reg, issuing_next;
    // Read data side of the scan, registered in the cycle after the issue side.
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;

    logic signed [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_reg, hi_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_min_reg, out_min_next;
    logic signed [SAMPLE_BITS-1:0] out_max_reg, out_max_next;
    logic [HELD_W-1:0]             out_held_reg, out_held_next;

    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic sample_acc;
    logic result_acc;
    logic rd_en;

    assign sample_acc = sample_valid && !sample_stall;
    assign result_acc = out_valid_reg && !result_stall;
    assign rd_en      = (state_reg == ST_SCAN) && issuing_reg;

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign window_min   = out_min_reg;
    assign window_max   = out_max_reg;
    assign samples_held = out_held_reg;

    // Sample ring: one write port at acceptance, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            ring_mem[write_slot_reg] <= sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[scan_idx_reg];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        scan_idx_next   = scan_idx_reg;
        issuing_next    = issuing_reg;
        rd_pend_next    = 1'b0;
        rd_last_next    = 1'b0;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        out_valid_next  = out_valid_reg && !result_acc;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_held_next   = out_held_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                                                    : write_slot_reg + 1'b1;
                    if (fill_count_reg != FULL_CNT)
                    begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    scan_idx_next = '0;
                    issuing_next  = 1'b1;
                    lo_next       = sample;
                    hi_next       = sample;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Held samples always sit in slots 0 .. fill-1, so the scan runs linearly.
                if (issuing_reg)
                begin
                    rd_pend_next = 1'b1;
                    if (FILL_W'(scan_idx_reg) == fill_count_reg - 1'b1)
                    begin
                        rd_last_next = 1'b1;
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (rd_data_reg < lo_reg)
                    begin
                        lo_next = rd_data_reg;
                    end
                    if (rd_data_reg > hi_reg)
                    begin
                        hi_next = rd_data_reg;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = lo_reg;
                    out_max_next   = hi_reg;
                    out_held_next  = HELD_W'(fill_count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            scan_idx_reg   <= '0;
            issuing_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            scan_idx_reg   <= scan_idx_next;
            issuing_reg    <= issuing_next;
            rd_pend_reg    <= rd_pend_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_held_reg <= out_held_next;
    end

`ifndef SYNTHESIS
    // The held count never passes the window size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FULL_CNT)
        else $error("fill count exceeds window");

    // The write slot stays inside the ring.
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot outside ring");

    // A new result is loaded only on leaving the done state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished scan");

    // Every finished scan has seen at least the new sample.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (lo_reg <= hi_reg) && (fill_count_reg != '0))
        else $error("scan finished with inconsistent extremes");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_min_max_core.sv =====
// Self-checking testbench for the sliding-window minimum/maximum core.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_core;
    import swmm_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int WIN         = WINDOW_DEF;
    localparam int RANDOM_BEATS = 1325;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    typedef struct packed
    {
        logic signed [SW-1:0]  lo;
        logic signed [SW-1:0]  hi;
        logic [HELD_W-1:0]     held;
    } window_result_t;

    typedef enum int
    {
        MIX_UNIFORM,
        MIX_RISE,
        MIX_FALL,
        MIX_FLAT,
        MIX_NOISY,
        MIX_CORNER
    } stim_mix_t;

    typedef enum int
    {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    logic signed [SW-1:0]  sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic signed [SW-1:0]  window_min;
    logic signed [SW-1:0]  window_max;
    logic [HELD_W-1:0]     samples_held;

    logic                  hold_off     = 1'b0;

    // Testbench copy of the window contents.
    logic signed [SW-1:0]  ring_copy [WIN];
    int unsigned           next_slot    = 0;
    int unsigned           held_count   = 0;

    logic signed [SW-1:0]  pending_samples [$];
    window_result_t        expected_windows [$];

    int                    fail_count   = 0;
    int                    beats_in     = 0;
    int                    beats_out    = 0;
    int                    full_windows = 0;
    int                    input_held_cycles = 0;

    int                    burst_left   = 0;
    int                    gap_left     = 0;
    stall_mode_t           stall_mode   = STALL_NONE;
    int                    stall_mode_left = 0;
    int unsigned           stall_phase  = 0;

    sliding_window_min_max_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_min   (window_min),
        .window_max   (window_max),
        .samples_held (samples_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Writes an accepted sample into the window copy and queues the extremes it yields.
    function automatic void absorb_sample(input logic signed [SW-1:0] s);
        window_result_t r;
        ring_copy[next_slot] = s;
        next_slot = (next_slot + 1 >= WIN) ? 0 : next_slot + 1;
        if (held_count < WIN)
            held_count++;
        if (held_count == WIN)
            full_windows++;
        // Slots fill from zero upward, so the first held_count slots are exactly the held ones.
        r.lo = s;
        r.hi = s;
        for (int i = 0; i < held_count; i++)
        begin
            if (ring_copy[i] < r.lo)
                r.lo = ring_copy[i];
            if (ring_copy[i] > r.hi)
                r.hi = ring_copy[i];
        end
        r.held = held_count[HELD_W-1:0];
        expected_windows.push_back(r);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        bit                   next_valid;
        logic signed [SW-1:0] next_sample;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                absorb_sample(sample);
                beats_in++;
            end
            if (hold_off && sample_valid && sample_stall)
                input_held_cycles++;
            if (!(sample_valid && sample_stall))
            begin
                next_valid  = 1'b0;
                next_sample = sample;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_samples.size() > 0)
                begin
                    next_valid  = 1'b1;
                    next_sample = pending_samples.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 35);
                    end
                    else
                        burst_left--;
                end
                sample_valid <= next_valid;
                sample       <= next_sample;
            end
        end
    end

    // Receiver: stall pattern that switches between modes, plus the long hold-off.
    always @(posedge clk)
    begin
        bit st;
        if (rst_n)
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode      = stall_mode_t'($urandom_range(0, 3));
                stall_mode_left = $urandom_range(20, 300);
            end
            else
                stall_mode_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:     st = 1'b0;
                STALL_RANDOM:   st = 1'($urandom_range(0, 1));
                STALL_PERIODIC: st = (stall_phase % 7) < 3;
                default:        st = ($urandom_range(0, 9) < 8);
            endcase
            result_stall <= st || hold_off;
        end
    end

    initial
    begin
        wait (rst_n);
        while (beats_out < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            beats_out++;
            if (expected_windows.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result beat: min %0d max %0d held %0d",
                             window_min, window_max, samples_held);
                fail_count++;
            end
            else
            begin
                want = expected_windows.pop_front();
                if (want.lo !== window_min || want.hi !== window_max
                    || want.held !== samples_held)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("result %0d: expected min %0d max %0d held %0d, got min %0d max %0d held %0d",
                                 beats_out, want.lo, want.hi, want.held,
                                 window_min, window_max, samples_held);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        stim_mix_t            mix;
        int                   seg_len;
        int                   level;
        logic signed [SW-1:0] v;

        // Extremes and sign-boundary patterns first, then enough beats to wrap the ring
        // so that the most negative sample ages out of a full window.
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'shFFFF);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shAAAA);
        for (int k = 0; k < 18; k++)
            pending_samples.push_back(SW'(k * 100 - 900));

        level = 0;
        while (pending_samples.size() < 25 + RANDOM_BEATS)
        begin
            mix     = stim_mix_t'($urandom_range(0, 5));
            seg_len = $urandom_range(8, 60);
            for (int k = 0; k < seg_len; k++)
            begin
                case (mix)
                    MIX_UNIFORM: v = SW'($urandom);
                    MIX_RISE:
                    begin
                        level += $urandom_range(0, 400);
                        v = SW'(level);
                    end
                    MIX_FALL:
                    begin
                        level -= $urandom_range(0, 400);
                        v = SW'(level);
                    end
                    MIX_FLAT:    v = SW'(level);
                    MIX_NOISY:   v = SW'(level + $urandom_range(0, 64) - 32);
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0:       v = 16'sh8000;
                            1:       v = 16'sh7FFF;
                            2:       v = 16'shFFFF;
                            3:       v = 16'sh0000;
                            default: v = SW'($urandom);
                        endcase
                    end
                endcase
                pending_samples.push_back(v);
            end
            if ($urandom_range(0, 3) == 0)
                level = $signed(SW'($urandom));
        end

        wait (rst_n);
        while (pending_samples.size() != 0 || sample_valid || expected_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_windows.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_windows.size());
            fail_count += expected_windows.size();
        end
        $display("covered %0d sample beats and %0d result beats, %0d with a full window",
                 beats_in, beats_out, full_windows);
        $display("input was held off for %0d cycles during a %0d-cycle output hold-off",
                 input_held_cycles, HOLD_CYCLES);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
